// ===== rtl/sampled_curve_peak_finder_defines.svh =====
// assertion macros shared by the checker
`ifndef SAMPLED_CURVE_PEAK_FINDER_DEFINES_SVH
`define SAMPLED_CURVE_PEAK_FINDER_DEFINES_SVH

// checked only while out of reset
`define SCPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset too
`define SCPF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/scpf_pkg.sv =====
package scpf_pkg;

    localparam int unsigned TIME_BITS_DEF  = 32;
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned FRAC_BITS      = 16;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } t_op;

endpackage

// ===== rtl/scpf_ifs.sv =====
interface scpf_pt_if #(
    parameter int unsigned TIME_BITS  = scpf_pkg::TIME_BITS_DEF,
    parameter int unsigned VALUE_BITS = scpf_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [TIME_BITS-1:0]         sample_time;
    logic signed [VALUE_BITS-1:0] sample_value;
    logic                         last_point;

    modport source (output valid, sample_time, sample_value, last_point, input ready);
    modport sink   (input valid, sample_time, sample_value, last_point, output ready);
endinterface

interface scpf_pk_if #(
    parameter int unsigned TIME_BITS  = scpf_pkg::TIME_BITS_DEF,
    parameter int unsigned VALUE_BITS = scpf_pkg::VALUE_BITS_DEF
);
    logic                                        valid;
    logic                                        ready;
    logic signed [VALUE_BITS-1:0]                peak_value;
    logic [TIME_BITS+scpf_pkg::FRAC_BITS-1:0]    peak_time;

    modport source (output valid, peak_value, peak_time, input ready);
    modport sink   (input valid, peak_value, peak_time, output ready);
endinterface

// ===== rtl/scpf_alu.sv =====
module scpf_alu #(
    parameter int unsigned W = 200
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  scpf_pkg::t_op  i_op,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic           o_done,
    output logic [W-1:0]   o_res
);
    import scpf_pkg::*;

    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    t_op           r_op;
    logic [W-1:0]  r_acc;   // accumulator or partial remainder
    logic [W-1:0]  r_x;     // multiplicand or divisor
    logic [W-1:0]  r_y;     // multiplier or dividend / quotient
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_res;

    logic [W:0]    add_x;
    logic [W:0]    add_y;
    logic          add_cin;
    logic [W+1:0]  add_s;

    logic          op_end;
    logic          last_step;

    // the one shared adder
    always_comb begin
        add_x   = {1'b0, r_acc};
        add_y   = {1'b0, r_x};
        add_cin = 1'b0;
        unique case (r_op)
            OP_SUB: begin
                add_y   = ~{1'b0, r_x};
                add_cin = 1'b1;
            end
            OP_DIV: begin
                add_x   = {r_acc, r_y[W-1]};
                add_y   = ~{1'b0, r_x};
                add_cin = 1'b1;
            end
            default: begin
                add_cin = 1'b0;
            end
        endcase
        add_s = {1'b0, add_x} + {1'b0, add_y} + (W+2)'(add_cin);
    end

    always_comb begin
        unique case (r_op)
            OP_ADD, OP_SUB: op_end = 1'b1;
            OP_MUL:         op_end = (r_y == '0);
            OP_DIV:         op_end = (r_cnt == '0);
            default:        op_end = 1'b1;
        endcase
    end

    assign last_step = r_busy && !i_start && op_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_ADD;
        end else begin
            r_done <= last_step;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_x    <= (i_op == OP_MUL) ? i_a : i_b;
                r_y    <= (i_op == OP_ADD || i_op == OP_SUB) ? '0 :
                          ((i_op == OP_DIV) ? i_a : i_b);
                r_acc  <= (i_op == OP_MUL || i_op == OP_DIV) ? '0 : i_a;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin
                        r_res  <= add_s[W-1:0];
                        r_busy <= 1'b0;
                    end
                    OP_MUL: begin
                        if (r_y == '0) begin
                            r_res  <= r_acc;
                            r_busy <= 1'b0;
                        end else begin
                            if (r_y[0]) begin
                                r_acc <= add_s[W-1:0];
                            end
                            r_x <= {r_x[W-2:0], 1'b0};
                            r_y <= {1'b0, r_y[W-1:1]};
                        end
                    end
                    OP_DIV: begin
                        // restoring step, carry out set means no borrow
                        r_acc <= add_s[W+1] ? add_s[W-1:0] : add_x[W-1:0];
                        r_y   <= {r_y[W-2:0], add_s[W+1]};
                        r_cnt <= r_cnt - CW'(1);
                        if (r_cnt == '0) begin
                            r_res  <= {r_y[W-2:0], add_s[W+1]};
                            r_busy <= 1'b0;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule

// ===== rtl/sampled_curve_peak_finder.sv =====
// Peak finder for a sampled curve, fed one point per word.
// i_pt carries sample_time (unsigned ticks), sample_value (signed Q16.16) and
// last_point; o_pk carries peak_value (Q16.16, saturated) and peak_time
// (unsigned Q32.16). Both use valid/ready; a word moves when both are high.
// i_cfg_we with i_cfg_wdata writes quadratic_mode (1 = parabola windows,
// 0 = largest sample); write it only between curves.
// In largest-sample mode, and for the first two points, a point goes straight
// from idle to the final state. A quadratic window runs up to 31 steps on one
// shared add/shift unit of W = 2*VALUE_BITS + 4*TIME_BITS + 8 bits: 15 add
// steps, 14 shift-add multiplies and two restoring divisions, then the pick
// and final states, after which the block takes the next point.
// The point marked last produces one peak word after its processing, then
// the curve state clears for the next curve.
// i_pt.ready is high only while the block is idle. The peak sits in an
// output register, so the next curve can start while it waits; a second
// peak is held back until the first one is taken.
// Reset (synchronous, active low) clears the curve, the mode register and
// the output valid.
module sampled_curve_peak_finder #(
    parameter int unsigned TIME_BITS  = scpf_pkg::TIME_BITS_DEF,
    parameter int unsigned VALUE_BITS = scpf_pkg::VALUE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    scpf_pt_if.sink    i_pt,
    scpf_pk_if.source  o_pk
);
    import scpf_pkg::*;

    localparam int unsigned W  = 2 * VALUE_BITS + 4 * TIME_BITS + 8;
    localparam int unsigned PT = TIME_BITS + FRAC_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_PICK,
        S_FINAL
    } t_state;

    typedef enum logic [4:0] {
        ST_V0D12, ST_V1D02, ST_A0, ST_V2D01, ST_A1,
        ST_N0, ST_V1D02B, ST_SQ02, ST_N1, ST_V2D01B, ST_SQ01, ST_N2,
        ST_QNEG, ST_QDBL, ST_PNEG, ST_LIM, ST_PCMP,
        ST_PSH, ST_PRND, ST_QQ, ST_UQ,
        ST_M0, ST_M1, ST_M2, ST_MDBL,
        ST_PSQ, ST_PDBL, ST_EADD, ST_MM, ST_EDIV, ST_EV0
    } t_step;

    typedef enum logic [3:0] {
        SRC_T1, SRC_T2, SRC_A, SRC_N, SRC_Q, SRC_P, SRC_M,
        SRC_V0, SRC_V1, SRC_V2, SRC_D01, SRC_D12, SRC_D02, SRC_D0102,
        SRC_ZERO, SRC_K17
    } t_src;

    typedef enum logic [2:0] {
        DST_T1, DST_T2, DST_A, DST_N, DST_Q, DST_P, DST_M
    } t_dst;

    t_state r_state;
    t_step  r_step;
    logic   r_mode;
    logic [1:0] r_cnt;
    logic [1:0] r_c;
    logic   r_last;
    logic   r_vok;

    logic [TIME_BITS-1:0]         r_t0, r_t1, r_ct;
    logic signed [VALUE_BITS-1:0] r_v0, r_v1, r_cv;
    logic signed [VALUE_BITS-1:0] r_bv;
    logic [PT-1:0]                r_bt;

    logic [W-1:0] r_w_t1, r_w_t2, r_w_a, r_w_n, r_w_q, r_w_p, r_w_m;

    logic                         r_out_valid;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic [PT-1:0]                r_out_time;

    // step decode
    t_op  st_op;
    t_src st_a, st_b;
    t_dst st_d;

    always_comb begin
        unique case (r_step)
            ST_V0D12:  begin st_op = OP_MUL; st_a = SRC_V0;   st_b = SRC_D12;   st_d = DST_T1; end
            ST_V1D02:  begin st_op = OP_MUL; st_a = SRC_V1;   st_b = SRC_D02;   st_d = DST_T2; end
            ST_A0:     begin st_op = OP_SUB; st_a = SRC_T1;   st_b = SRC_T2;    st_d = DST_A;  end
            ST_V2D01:  begin st_op = OP_MUL; st_a = SRC_V2;   st_b = SRC_D01;   st_d = DST_T2; end
            ST_A1:     begin st_op = OP_ADD; st_a = SRC_A;    st_b = SRC_T2;    st_d = DST_A;  end
            ST_N0:     begin st_op = OP_MUL; st_a = SRC_T1;   st_b = SRC_D0102; st_d = DST_T1; end
            ST_V1D02B: begin st_op = OP_MUL; st_a = SRC_V1;   st_b = SRC_D02;   st_d = DST_T2; end
            ST_SQ02:   begin st_op = OP_MUL; st_a = SRC_T2;   st_b = SRC_D02;   st_d = DST_T2; end
            ST_N1:     begin st_op = OP_SUB; st_a = SRC_T1;   st_b = SRC_T2;    st_d = DST_N;  end
            ST_V2D01B: begin st_op = OP_MUL; st_a = SRC_V2;   st_b = SRC_D01;   st_d = DST_T2; end
            ST_SQ01:   begin st_op = OP_MUL; st_a = SRC_T2;   st_b = SRC_D01;   st_d = DST_T2; end
            ST_N2:     begin st_op = OP_ADD; st_a = SRC_N;    st_b = SRC_T2;    st_d = DST_N;  end
            ST_QNEG:   begin st_op = OP_SUB; st_a = SRC_ZERO; st_b = SRC_A;     st_d = DST_Q;  end
            ST_QDBL:   begin st_op = OP_ADD; st_a = SRC_Q;    st_b = SRC_Q;     st_d = DST_Q;  end
            ST_PNEG:   begin st_op = OP_SUB; st_a = SRC_ZERO; st_b = SRC_N;     st_d = DST_P;  end
            ST_LIM:    begin st_op = OP_MUL; st_a = SRC_Q;    st_b = SRC_D02;   st_d = DST_T1; end
            ST_PCMP:   begin st_op = OP_SUB; st_a = SRC_P;    st_b = SRC_T1;    st_d = DST_T2; end
            ST_PSH:    begin st_op = OP_MUL; st_a = SRC_P;    st_b = SRC_K17;   st_d = DST_T1; end
            ST_PRND:   begin st_op = OP_ADD; st_a = SRC_T1;   st_b = SRC_Q;     st_d = DST_T1; end
            ST_QQ:     begin st_op = OP_ADD; st_a = SRC_Q;    st_b = SRC_Q;     st_d = DST_T2; end
            ST_UQ:     begin st_op = OP_DIV; st_a = SRC_T1;   st_b = SRC_T2;    st_d = DST_A;  end
            ST_M0:     begin st_op = OP_MUL; st_a = SRC_Q;    st_b = SRC_D01;   st_d = DST_M;  end
            ST_M1:     begin st_op = OP_MUL; st_a = SRC_M;    st_b = SRC_D12;   st_d = DST_M;  end
            ST_M2:     begin st_op = OP_MUL; st_a = SRC_M;    st_b = SRC_D02;   st_d = DST_M;  end
            ST_MDBL:   begin st_op = OP_ADD; st_a = SRC_M;    st_b = SRC_M;     st_d = DST_M;  end
            ST_PSQ:    begin st_op = OP_MUL; st_a = SRC_P;    st_b = SRC_P;     st_d = DST_T1; end
            ST_PDBL:   begin st_op = OP_ADD; st_a = SRC_T1;   st_b = SRC_T1;    st_d = DST_T1; end
            ST_EADD:   begin st_op = OP_ADD; st_a = SRC_T1;   st_b = SRC_M;     st_d = DST_T1; end
            ST_MM:     begin st_op = OP_ADD; st_a = SRC_M;    st_b = SRC_M;     st_d = DST_T2; end
            ST_EDIV:   begin st_op = OP_DIV; st_a = SRC_T1;   st_b = SRC_T2;    st_d = DST_N;  end
            ST_EV0:    begin st_op = OP_ADD; st_a = SRC_N;    st_b = SRC_V0;    st_d = DST_N;  end
            default:   begin st_op = OP_ADD; st_a = SRC_ZERO; st_b = SRC_ZERO;  st_d = DST_T1; end
        endcase
    end

    // window differences, valid only when times increase
    logic [TIME_BITS-1:0] d01, d12;
    logic [TIME_BITS:0]   d02;
    logic [TIME_BITS+1:0] d0102;

    assign d01   = r_t1 - r_t0;
    assign d12   = r_ct - r_t1;
    assign d02   = {1'b0, r_ct} - {1'b0, r_t0};
    assign d0102 = {2'b0, d01} + {1'b0, d02};

    logic [W-1:0] src_val [16];
    logic [W-1:0] alu_a, alu_b, alu_res;
    logic         alu_done;

    always_comb begin
        src_val[SRC_T1]    = r_w_t1;
        src_val[SRC_T2]    = r_w_t2;
        src_val[SRC_A]     = r_w_a;
        src_val[SRC_N]     = r_w_n;
        src_val[SRC_Q]     = r_w_q;
        src_val[SRC_P]     = r_w_p;
        src_val[SRC_M]     = r_w_m;
        src_val[SRC_V0]    = {{(W-VALUE_BITS){r_v0[VALUE_BITS-1]}}, r_v0};
        src_val[SRC_V1]    = {{(W-VALUE_BITS){r_v1[VALUE_BITS-1]}}, r_v1};
        src_val[SRC_V2]    = {{(W-VALUE_BITS){r_cv[VALUE_BITS-1]}}, r_cv};
        src_val[SRC_D01]   = {{(W-TIME_BITS){1'b0}}, d01};
        src_val[SRC_D12]   = {{(W-TIME_BITS){1'b0}}, d12};
        src_val[SRC_D02]   = {{(W-TIME_BITS-1){1'b0}}, d02};
        src_val[SRC_D0102] = {{(W-TIME_BITS-2){1'b0}}, d0102};
        src_val[SRC_ZERO]  = '0;
        src_val[SRC_K17]   = W'(1) << (FRAC_BITS + 1);
    end

    assign alu_a = src_val[st_a];
    assign alu_b = src_val[st_b];

    scpf_alu #(
        .W(W)
    ) u_scpf_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_ISSUE),
        .i_op    (st_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    // window offer
    logic [W-1:0]                 max_w;
    logic signed [VALUE_BITS-1:0] fv;
    logic                         v_ok;
    logic signed [VALUE_BITS-1:0] wv;
    logic [PT-1:0]                wt;
    logic signed [VALUE_BITS-1:0] fin_v;
    logic [PT-1:0]                fin_t;
    logic                         p_ok;

    assign max_w = {{(W-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
    assign fv    = ($signed(r_w_n) > $signed(max_w)) ? max_w[VALUE_BITS-1:0]
                                                     : r_w_n[VALUE_BITS-1:0];
    assign v_ok  = r_vok && (fv >= r_v0) && (fv >= r_v1) && (fv >= r_cv);
    assign p_ok  = !r_w_p[W-1] && (r_w_p != '0) && alu_res[W-1];

    always_comb begin
        if (v_ok) begin
            wv = fv;
            wt = {r_t0, {FRAC_BITS{1'b0}}} + r_w_a[PT-1:0];
        end else if (r_cv > r_v0) begin
            wv = r_cv;
            wt = {r_ct, {FRAC_BITS{1'b0}}};
        end else begin
            wv = r_v0;
            wt = {r_t0, {FRAC_BITS{1'b0}}};
        end
        if (r_mode && r_c == 2'd1 && r_cv > r_bv) begin
            fin_v = r_cv;
            fin_t = {r_ct, {FRAC_BITS{1'b0}}};
        end else begin
            fin_v = r_bv;
            fin_t = r_bt;
        end
    end

    logic in_acc;
    logic out_load;
    assign in_acc   = i_pt.valid && i_pt.ready;
    assign out_load = (r_state == S_FINAL) && r_last && (!r_out_valid || o_pk.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
            r_bv        <= '0;
            r_bt        <= '0;
            r_t0        <= '0;
            r_v0        <= '0;
            r_t1        <= '0;
            r_v1        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_pk.valid && o_pk.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ct   <= i_pt.sample_time;
                        r_cv   <= i_pt.sample_value;
                        r_last <= i_pt.last_point;
                        r_c    <= r_cnt;
                        r_step <= ST_V0D12;
                        if (r_cnt == 2'd0 ||
                            (!r_mode && i_pt.sample_value > r_bv)) begin
                            r_bv <= i_pt.sample_value;
                            r_bt <= {i_pt.sample_time, {FRAC_BITS{1'b0}}};
                        end
                        if (r_mode && r_cnt == 2'd2) begin
                            if (r_t1 > r_t0 && i_pt.sample_time > r_t1) begin
                                r_state <= S_ISSUE;
                            end else begin
                                r_vok   <= 1'b0;
                                r_state <= S_PICK;
                            end
                        end else begin
                            r_state <= S_FINAL;
                        end
                    end
                end
                S_ISSUE: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (alu_done) begin
                        unique case (st_d)
                            DST_T1:  r_w_t1 <= alu_res;
                            DST_T2:  r_w_t2 <= alu_res;
                            DST_A:   r_w_a  <= alu_res;
                            DST_N:   r_w_n  <= alu_res;
                            DST_Q:   r_w_q  <= alu_res;
                            DST_P:   r_w_p  <= alu_res;
                            DST_M:   r_w_m  <= alu_res;
                            default: r_w_t1 <= alu_res;
                        endcase
                        // convex or flat window, vertex outside, or done
                        if (r_step == ST_N2 && !r_w_a[W-1]) begin
                            r_vok   <= 1'b0;
                            r_state <= S_PICK;
                        end else if (r_step == ST_PCMP && !p_ok) begin
                            r_vok   <= 1'b0;
                            r_state <= S_PICK;
                        end else if (r_step == ST_EV0) begin
                            r_vok   <= 1'b1;
                            r_state <= S_PICK;
                        end else begin
                            r_step  <= t_step'(r_step + 5'd1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_PICK: begin
                    if (wv > r_bv) begin
                        r_bv <= wv;
                        r_bt <= wt;
                    end
                    r_state <= S_FINAL;
                end
                S_FINAL: begin
                    if (r_last) begin
                        if (out_load) begin
                            r_out_value <= fin_v;
                            r_out_time  <= fin_t;
                            r_t0        <= '0;
                            r_v0        <= '0;
                            r_t1        <= '0;
                            r_v1        <= '0;
                            r_cnt       <= 2'd0;
                            r_bv        <= '0;
                            r_bt        <= '0;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_t0    <= r_t1;
                        r_v0    <= r_v1;
                        r_t1    <= r_ct;
                        r_v1    <= r_cv;
                        r_cnt   <= (r_cnt == 2'd2) ? 2'd2 : r_cnt + 2'd1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_pt.ready      = (r_state == S_IDLE);
    assign o_pk.valid      = r_out_valid;
    assign o_pk.peak_value = r_out_value;
    assign o_pk.peak_time  = r_out_time;
endmodule

// ===== rtl/scpf_checker.sv =====
`include "sampled_curve_peak_finder_defines.svh"

module scpf_checker #(
    parameter int unsigned TIME_BITS  = scpf_pkg::TIME_BITS_DEF,
    parameter int unsigned VALUE_BITS = scpf_pkg::VALUE_BITS_DEF
) (
    input logic                                     i_clk,
    input logic                                     i_rst_n,
    input logic                                     i_in_valid,
    input logic                                     i_in_ready,
    input logic                                     i_out_valid,
    input logic                                     i_out_ready,
    input logic [VALUE_BITS-1:0]                    i_out_value,
    input logic [TIME_BITS+scpf_pkg::FRAC_BITS-1:0] i_out_time
);
    import scpf_pkg::*;

    // no peak word right after reset
    `SCPF_ASSERT_NR(a_rst_no_out, !i_rst_n |=> !i_out_valid, "peak valid after reset")

    // a stalled peak word holds
    `SCPF_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) && $stable(i_out_time), "peak word changed while stalled")

    // after a point is taken, ready is low in the following cycle
    `SCPF_ASSERT(a_busy_after_accept, i_in_valid && i_in_ready |=> !i_in_ready, "ready right after accept")
endmodule

bind sampled_curve_peak_finder scpf_checker #(
    .TIME_BITS  (TIME_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_scpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_pk.valid),
    .i_out_ready (o_pk.ready),
    .i_out_value (o_pk.peak_value),
    .i_out_time  (o_pk.peak_time)
);
